[sv/sbus_pkg.sv]
// Shared constants of the S-BUS frame decoder.
`timescale 1ns / 1ps
package sbus_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int STORE_BYTES   = FRAME_BYTES - 2;
    localparam int STORE_W       = STORE_BYTES * 8;
    localparam int FLAGS_LSB     = (STORE_BYTES - 1) * 8;
    localparam int FAILSAFE_BIT  = 3;
    localparam int VALUE_BITS    = 11;
    localparam int INDEX_BITS    = 4;
    localparam int POS_BITS      = 5;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] START_MARK = 8'h0F;
    localparam logic [7:0] END_MARK   = 8'h00;

    localparam logic [POS_BITS-1:0] START_POS = POS_BITS'(0);
    localparam logic [POS_BITS-1:0] END_POS   = POS_BITS'(FRAME_BYTES - 1);

endpackage

[sv/sbus_ifs.sv]
// Handshake channels of the S-BUS frame decoder: received bytes and channel results.
`timescale 1ns / 1ps
interface sbus_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbus_chan_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        link_active;
    logic        last;

    modport source (output valid, output channel_index, output channel_value,
                    output link_active, output last, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input link_active, input last, output ready);
endinterface

[sv/sbus_front.sv]
// Byte framing: tracks the frame position, checks the marks and collects the frame body.
`timescale 1ns / 1ps
module sbus_front #(
    parameter int PAYLOAD_W = 176
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sbus_byte_if.sink            i_rx,
    input  logic                 i_q_full,
    output logic                 o_push,
    output logic [PAYLOAD_W:0]   o_push_data
);
    import sbus_pkg::*;

    logic [POS_BITS-1:0] r_pos;
    logic [POS_BITS-1:0] n_pos;
    logic [STORE_W-1:0]  r_store;
    logic                at_start;
    logic                at_end;
    logic                accept;

    // Positions beyond the end mark never occur, but count as the start.
    assign at_start = (r_pos == START_POS) || (r_pos > END_POS);
    assign at_end   = (r_pos == END_POS);

    // The end byte is only taken when the queue has room for the frame.
    assign i_rx.ready = !(at_end && i_q_full);
    assign accept     = i_rx.valid && i_rx.ready;

    assign o_push      = accept && at_end && (i_rx.rx_byte == END_MARK);
    assign o_push_data = {~r_store[FLAGS_LSB + FAILSAFE_BIT], r_store[PAYLOAD_W-1:0]};

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            priority if (at_start) begin
                n_pos = (i_rx.rx_byte == START_MARK) ? POS_BITS'(1) : START_POS;
            end else if (at_end) begin
                n_pos = START_POS;
            end else begin
                n_pos = r_pos + POS_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= START_POS;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Body bytes shift in from the top, so the first one ends up lowest.
    always_ff @(posedge i_clk) begin
        if (accept && !at_start && !at_end) begin
            r_store <= {i_rx.rx_byte, r_store[STORE_W-1:8]};
        end
    end

endmodule

[sv/sbus_queue.sv]
// Small frame queue between the framing and channel output sides.
`timescale 1ns / 1ps
module sbus_queue #(
    parameter int WIDTH = 177
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_nonempty
);
    import sbus_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/sbus_back.sv]
// Channel output: unpacks one queued frame into per-channel result words.
`timescale 1ns / 1ps
module sbus_back #(
    parameter int NUM_CHANNELS = 16,
    parameter int PAYLOAD_W    = 176
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [PAYLOAD_W:0] i_q_data,
    input  logic               i_q_nonempty,
    output logic               o_pop,
    sbus_chan_if.source        o_ch
);
    import sbus_pkg::*;

    localparam logic [INDEX_BITS-1:0] LAST_CH = INDEX_BITS'(NUM_CHANNELS - 1);

    logic                   r_valid;
    logic [INDEX_BITS-1:0]  r_ch;
    logic [PAYLOAD_W-1:0]   r_shift;
    logic                   r_active;
    logic                   out_accept;
    logic                   at_last;

    assign at_last    = (r_ch == LAST_CH);
    assign out_accept = o_ch.valid && o_ch.ready;
    // A new frame loads when idle or as the last word of the current one leaves.
    assign o_pop      = i_q_nonempty && (!r_valid || (out_accept && at_last));

    assign o_ch.valid         = r_valid;
    assign o_ch.channel_index = r_ch;
    assign o_ch.channel_value = r_shift[VALUE_BITS-1:0];
    assign o_ch.link_active   = r_active;
    assign o_ch.last          = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ch    <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_ch    <= '0;
            end else if (out_accept) begin
                if (at_last) begin
                    r_valid <= 1'b0;
                end else begin
                    r_ch <= r_ch + INDEX_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift  <= i_q_data[PAYLOAD_W-1:0];
            r_active <= i_q_data[PAYLOAD_W];
        end else if (out_accept && !at_last) begin
            r_shift <= r_shift >> VALUE_BITS;
        end
    end

endmodule

[sv/sbus_frame_decoder.sv]
// Top level of the S-BUS frame decoder: framing side, frame queue and channel output side.
`timescale 1ns / 1ps
// The decoder takes one received serial byte per word on i_rx and assembles 25-byte
// frames. A frame opens with 0x0F and closes with 0x00; a wrong opening byte is dropped,
// and a wrong closing byte abandons the frame, so the next byte is again checked as an
// opening byte. For every good frame the block gives NUM_CHANNELS words on o_ch, in
// channel order: the channel number, its 11-bit value taken least significant bit first
// from bit 11*n of the payload, the link-active flag (failsafe bit clear in the flags
// byte), and a last flag on the final channel. Bytes are accepted one per cycle; the only
// stall on the input is the closing byte of a frame while both queue entries hold frames
// not yet sent. The output side sends one channel word per cycle while o_ch.ready is
// high, unpacking one frame at a time in the single shift register; up to two finished
// frames wait in the queue meanwhile. Reset clears the frame position and the queue; no
// clearing pass is needed.
module sbus_frame_decoder #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbus_byte_if.sink   i_rx,
    sbus_chan_if.source o_ch
);
    import sbus_pkg::*;

    // Only the payload bits that the configured channels read are carried past framing.
    localparam int PAYLOAD_W = NUM_CHANNELS * VALUE_BITS;

    logic                 push;
    logic [PAYLOAD_W:0]   push_data;
    logic                 pop;
    logic [PAYLOAD_W:0]   q_data;
    logic                 q_full;
    logic                 q_nonempty;

    // The framing side sees every byte and hands over complete frames only.
    sbus_front #(
        .PAYLOAD_W (PAYLOAD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Each entry holds the link-active flag above the payload bits.
    sbus_queue #(
        .WIDTH (PAYLOAD_W + 1)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_data),
        .i_pop      (pop),
        .o_data     (q_data),
        .o_full     (q_full),
        .o_nonempty (q_nonempty)
    );

    // The output side walks through one frame at a time, shifting out a channel per word.
    sbus_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .PAYLOAD_W    (PAYLOAD_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_data     (q_data),
        .i_q_nonempty (q_nonempty),
        .o_pop        (pop),
        .o_ch         (o_ch)
    );

endmodule
